// File: hw/rtl/aes_pkg.sv
// AES cipher package: substitution tables, round transforms and shared types.
// No dependencies; used by the key expansion, round and top-level modules.
`timescale 1ns / 1ps

package aes_pkg;

    localparam logic [2:0] REG_KEY0    = 3'd0;
    localparam logic [2:0] REG_KEY1    = 3'd1;
    localparam logic [2:0] REG_KEY2    = 3'd2;
    localparam logic [2:0] REG_KEY3    = 3'd3;
    localparam logic [2:0] REG_IV_HIGH = 3'd4;
    localparam logic [2:0] REG_IV_LOW  = 3'd5;
    localparam logic [2:0] REG_KEYSIZE = 3'd6;
    localparam logic [2:0] REG_OPMODE  = 3'd7;

    localparam logic [7:0] RC_INIT = 8'h01;

    typedef struct packed {
        logic busy;
        logic done;
        logic we;
    } kx_stat_t;

    localparam logic [2047:0] FWD_SBOX = {
        128'h637C777BF26B6FC53001672BFED7AB76,
        128'hCA82C97DFA5947F0ADD4A2AF9CA472C0,
        128'hB7FD9326363FF7CC34A5E5F171D83115,
        128'h04C723C31896059A071280E2EB27B275,
        128'h09832C1A1B6E5AA0523BD6B329E32F84,
        128'h53D100ED20FCB15B6ACBBE394A4C58CF,
        128'hD0EFAAFB434D338545F9027F503C9FA8,
        128'h51A3408F929D38F5BCB6DA2110FFF3D2,
        128'hCD0C13EC5F974417C4A77E3D645D1973,
        128'h60814FDC222A908846EEB814DE5E0BDB,
        128'hE0323A0A4906245CC2D3AC629195E479,
        128'hE7C8376D8DD54EA96C56F4EA657AAE08,
        128'hBA78252E1CA6B4C6E8DD741F4BBD8B8A,
        128'h703EB5664803F60E613557B986C11D9E,
        128'hE1F8981169D98E949B1E87E9CE5528DF,
        128'h8CA1890DBFE6426841992D0FB054BB16
    };

    localparam logic [2047:0] INV_SBOX = {
        128'h52096AD53036A538BF40A39E81F3D7FB,
        128'h7CE339829B2FFF87348E4344C4DEE9CB,
        128'h547B9432A6C2233DEE4C950B42FAC34E,
        128'h082EA16628D924B2765BA2496D8BD125,
        128'h72F8F66486689816D4A45CCC5D65B692,
        128'h6C704850FDEDB9DA5E154657A78D9D84,
        128'h90D8AB008CBCD30AF7E45805B8B34506,
        128'hD02C1E8FCA3F0F02C1AFBD0301138A6B,
        128'h3A9111414F67DCEA97F2CFCEF0B4E673,
        128'h96AC7422E7AD3585E2F937E81C75DF6E,
        128'h47F11A711D29C5896FB7620EAA18BE1B,
        128'hFC563E4BC6D279209ADBC0FE78CD5AF4,
        128'h1FDDA8338807C731B11210592780EC5F,
        128'h60517FA919B54A0D2DE57A9F93C99CEF,
        128'hA0E03B4DAE2AF5B0C8EBBB3C83539961,
        128'h172B047EBA77D626E169146355210C7D
    };

    function automatic logic [7:0] sbox(input logic [7:0] x, input logic inv);
        logic [7:0] r;
        if (inv)
        begin
            r = INV_SBOX[2047 - 8 * x -: 8];
        end
        else
        begin
            r = FWD_SBOX[2047 - 8 * x -: 8];
        end
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24], 1'b0), sbox(w[23:16], 1'b0),
                sbox(w[15:8], 1'b0), sbox(w[7:0], 1'b0)};
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int n = 0; n < 16; n++)
        begin
            t[127 - 8 * n -: 8] = sbox(s[127 - 8 * n -: 8], inv);
        end
        return t;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        int src;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
                t[127 - 8 * (4 * c + r) -: 8] = s[127 - 8 * (4 * src + r) -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0] b [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                b[k]  = s[127 - 8 * (4 * c + k) -: 8];
                x2[k] = xt(b[k]);
                x4[k] = xt(x2[k]);
                x8[k] = xt(x4[k]);
            end
            for (int r = 0; r < 4; r++)
            begin
                if (inv)
                begin
                    t[127 - 8 * (4 * c + r) -: 8] =
                        (x8[r] ^ x4[r] ^ x2[r]) ^
                        (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ b[(r + 1) % 4]) ^
                        (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ b[(r + 2) % 4]) ^
                        (x8[(r + 3) % 4] ^ b[(r + 3) % 4]);
                end
                else
                begin
                    t[127 - 8 * (4 * c + r) -: 8] =
                        x2[r] ^ x2[(r + 1) % 4] ^ b[(r + 1) % 4] ^
                        b[(r + 2) % 4] ^ b[(r + 3) % 4];
                end
            end
        end
        return t;
    endfunction

endpackage

// File: hw/rtl/aes_if.sv
// Block transfer channels: input block and result block with valid/ready.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

interface aes_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    logic        first_block;

    modport source (output valid, output block_hi, output block_lo,
                    output first_block, input ready);
    modport sink (input valid, input block_hi, input block_lo,
                  input first_block, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_hi;
    logic [63:0] result_lo;

    modport source (output valid, output result_hi, output result_lo, input ready);
    modport sink (input valid, input result_hi, input result_lo, output ready);
endinterface

// File: hw/rtl/aes_block_cipher_ecb_cbc.sv
// AES-128/192/256 block cipher, ECB or CBC, encrypt or decrypt. One block is
// in flight at a time: after the transfer, the FETCH state reads the first round
// key, the RUN state does the initial round-key add, and then the single shared
// round unit does one round per cycle until the result is valid. After any write
// to a key register or key_size, the next block first runs the key expansion,
// one schedule word per cycle. Registers sit on an APB port at byte address
// 8 * index, 64 bits wide. KEY_SCHEDULE_WORDS sizes the round-key store; a key
// size whose schedule does not fit falls back to the largest one that does.
`timescale 1ns / 1ps

module aes_block_cipher_ecb_cbc #(
    parameter int KEY_SCHEDULE_WORDS = 60
) (
    input  logic        clk,
    input  logic        rst_n,
    aes_in_if.sink      blk_in,
    aes_out_if.source   blk_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int ROWS    = KEY_SCHEDULE_WORDS / 4;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int MAX_SEL = (KEY_SCHEDULE_WORDS >= 60) ? 2 :
                             (KEY_SCHEDULE_WORDS >= 52) ? 1 : 0;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXPAND = 5'b00010,
        ST_FETCH  = 5'b00100,
        ST_RUN    = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t       state_reg, state_next;
    logic [63:0]  key0_reg, key1_reg, key2_reg, key3_reg;
    logic [63:0]  iv_hi_reg, iv_lo_reg;
    logic [1:0]   key_size_reg;
    logic [1:0]   op_mode_reg;
    logic         keys_ready_reg;
    logic [127:0] chain_reg;
    logic [127:0] ch_reg;
    logic [127:0] st_reg;
    logic [ROW_W-1:0] step_reg;
    logic [ROW_W-1:0] nr_reg;
    logic [127:0] res_reg;
    logic         out_valid_reg;
    logic [127:0] rk_mem [ROWS];
    logic [127:0] rk_rdata_reg;

    logic         cfg_wr;
    logic [1:0]   sel;
    logic [ROW_W-1:0] nr_sel;
    logic         cbc, dec;
    logic         in_xfer, out_xfer;
    logic         kx_start;
    aes_pkg::kx_stat_t kx_stat;
    logic [ROW_W-1:0] kx_addr;
    logic [127:0] kx_data;
    logic [ROW_W-1:0] rd_step;
    logic [ROW_W-1:0] rd_addr;
    logic [127:0] rnd_out;
    logic [127:0] st_new;
    logic [127:0] ch_in;
    logic         run_last;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cbc     = op_mode_reg[0];
    assign dec     = op_mode_reg[1];
    assign in_xfer  = blk_in.valid & blk_in.ready;
    assign out_xfer = blk_out.valid & blk_out.ready;
    assign blk_in.ready     = (state_reg == ST_IDLE);
    assign blk_out.valid    = out_valid_reg;
    assign blk_out.result_hi = res_reg[127:64];
    assign blk_out.result_lo = res_reg[63:0];
    assign kx_start = in_xfer & ~keys_ready_reg;
    assign run_last = (step_reg == nr_reg);
    assign ch_in    = blk_in.first_block ? {iv_hi_reg, iv_lo_reg} : chain_reg;

    always_comb
    begin
        if (key_size_reg == 2'd0)
        begin
            sel = 2'd0;
        end
        else if (key_size_reg == 2'd1)
        begin
            sel = 2'd1;
        end
        else
        begin
            sel = 2'd2;
        end
        if (sel > 2'(MAX_SEL))
        begin
            sel = 2'(MAX_SEL);
        end
        nr_sel = ROW_W'(4'd10 + {1'b0, sel, 1'b0});
    end

    always_comb
    begin
        unique case (paddr[5:3])
            aes_pkg::REG_KEY0:    prdata = key0_reg;
            aes_pkg::REG_KEY1:    prdata = key1_reg;
            aes_pkg::REG_KEY2:    prdata = key2_reg;
            aes_pkg::REG_KEY3:    prdata = key3_reg;
            aes_pkg::REG_IV_HIGH: prdata = iv_hi_reg;
            aes_pkg::REG_IV_LOW:  prdata = iv_lo_reg;
            aes_pkg::REG_KEYSIZE: prdata = {62'd0, key_size_reg};
            default:              prdata = {62'd0, op_mode_reg};
        endcase
    end

    aes_key_exp #(
        .KEY_SCHEDULE_WORDS(KEY_SCHEDULE_WORDS)
    ) u_key_exp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (kx_start),
        .key     ({key0_reg, key1_reg, key2_reg, key3_reg}),
        .sel     (sel),
        .nr      (nr_sel),
        .stat    (kx_stat),
        .wr_addr (kx_addr),
        .wr_data (kx_data)
    );

    aes_round u_round (
        .state_in  (st_reg),
        .round_key (rk_rdata_reg),
        .dec       (dec),
        .last      (run_last),
        .state_out (rnd_out)
    );

    always_comb
    begin
        rd_step = '0;
        if (state_reg == ST_RUN && !run_last)
        begin
            rd_step = step_reg + 1'b1;
        end
        rd_addr = dec ? (nr_reg - rd_step) : rd_step;
        st_new  = (step_reg == '0) ? (st_reg ^ rk_rdata_reg) : rnd_out;
    end

    always_ff @(posedge clk)
    begin
        if (kx_stat.we)
        begin
            rk_mem[kx_addr] <= kx_data;
        end
        rk_rdata_reg <= rk_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = keys_ready_reg ? ST_FETCH : ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                if (kx_stat.done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (run_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_xfer)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key0_reg       <= '0;
            key1_reg       <= '0;
            key2_reg       <= '0;
            key3_reg       <= '0;
            iv_hi_reg      <= '0;
            iv_lo_reg      <= '0;
            key_size_reg   <= '0;
            op_mode_reg    <= '0;
            keys_ready_reg <= 1'b0;
            chain_reg      <= '0;
            nr_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (kx_stat.done)
            begin
                keys_ready_reg <= 1'b1;
                nr_reg         <= nr_sel;
            end
            if (cfg_wr)
            begin
                unique case (paddr[5:3])
                    aes_pkg::REG_KEY0:
                    begin
                        key0_reg <= pwdata;
                        keys_ready_reg <= 1'b0;
                    end
                    aes_pkg::REG_KEY1:
                    begin
                        key1_reg <= pwdata;
                        keys_ready_reg <= 1'b0;
                    end
                    aes_pkg::REG_KEY2:
                    begin
                        key2_reg <= pwdata;
                        keys_ready_reg <= 1'b0;
                    end
                    aes_pkg::REG_KEY3:
                    begin
                        key3_reg <= pwdata;
                        keys_ready_reg <= 1'b0;
                    end
                    aes_pkg::REG_IV_HIGH: iv_hi_reg <= pwdata;
                    aes_pkg::REG_IV_LOW:  iv_lo_reg <= pwdata;
                    aes_pkg::REG_KEYSIZE:
                    begin
                        key_size_reg <= pwdata[1:0];
                        keys_ready_reg <= 1'b0;
                    end
                    default: op_mode_reg <= pwdata[1:0];
                endcase
            end
            if (in_xfer && dec)
            begin
                chain_reg <= {blk_in.block_hi, blk_in.block_lo};
            end
            if (state_reg == ST_RUN && run_last)
            begin
                out_valid_reg <= 1'b1;
                if (!dec)
                begin
                    chain_reg <= st_new;
                end
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ch_reg <= ch_in;
            st_reg <= {blk_in.block_hi, blk_in.block_lo} ^ ((cbc && !dec) ? ch_in : '0);
        end
        else if (state_reg == ST_RUN)
        begin
            st_reg <= st_new;
        end
        if (state_reg == ST_FETCH)
        begin
            step_reg <= '0;
        end
        else if (state_reg == ST_RUN)
        begin
            step_reg <= step_reg + 1'b1;
        end
        if (state_reg == ST_RUN && run_last)
        begin
            res_reg <= (cbc && dec) ? (st_new ^ ch_reg) : st_new;
        end
    end

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        blk_in.ready |-> !blk_out.valid)
        else $error("input ready while a result is pending");

    a_run_keys: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> keys_ready_reg)
        else $error("rounds running without an expanded key");

    a_kx_state: assert property (@(posedge clk) disable iff (!rst_n)
        kx_stat.busy |-> (state_reg == ST_EXPAND))
        else $error("key expansion active outside expand state");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= nr_reg))
        else $error("round step past last round");

    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && run_last) |=> blk_out.valid)
        else $error("result not presented after last round");

endmodule

// File: hw/rtl/aes_key_exp.sv
// AES key expansion: one schedule word per cycle, one 128-bit row written every
// fourth word. Depends on aes_pkg.
`timescale 1ns / 1ps

module aes_key_exp #(
    parameter int KEY_SCHEDULE_WORDS = 60
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [255:0]            key,
    input  logic [1:0]              sel,
    input  logic [$clog2(KEY_SCHEDULE_WORDS / 4) - 1:0] nr,
    output aes_pkg::kx_stat_t       stat,
    output logic [$clog2(KEY_SCHEDULE_WORDS / 4) - 1:0] wr_addr,
    output logic [127:0]            wr_data
);

    localparam int ROW_W = $clog2(KEY_SCHEDULE_WORDS / 4);
    localparam int WI_W  = ROW_W + 2;

    logic            busy_reg;
    logic [WI_W-1:0] i_reg;
    logic [2:0]      mcnt_reg;
    logic [7:0]      rc_reg;
    logic [31:0]     win_reg [8];

    logic [3:0]  nk;
    logic        ld;
    logic        last;
    logic [31:0] wk;
    logic [31:0] t;
    logic [31:0] w_new;

    always_comb
    begin
        nk   = 4'd4 + {1'b0, sel, 1'b0};
        ld   = {{(WI_W > 4 ? WI_W - 4 : 0){1'b0}}, nk} > WI_W'(i_reg) ? 1'b1 : 1'b0;
        last = (i_reg == WI_W'({nr, 2'b11}));
        unique case (sel)
            2'd0:    wk = win_reg[3];
            2'd1:    wk = win_reg[5];
            default: wk = win_reg[7];
        endcase
        t = win_reg[0];
        if (mcnt_reg == 3'd0)
        begin
            t = aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc_reg, 24'd0};
        end
        else if (sel == 2'd2 && i_reg[1:0] == 2'd0)
        begin
            t = aes_pkg::sub_word(t);
        end
        w_new = ld ? key[255 - 32 * i_reg[2:0] -: 32] : (wk ^ t);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && last)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            i_reg    <= '0;
            mcnt_reg <= 3'd0;
            rc_reg   <= aes_pkg::RC_INIT;
        end
        else if (busy_reg)
        begin
            i_reg    <= i_reg + 1'b1;
            mcnt_reg <= ({1'b0, mcnt_reg} == nk - 4'd1) ? 3'd0 : mcnt_reg + 3'd1;
            if (!ld && mcnt_reg == 3'd0)
            begin
                rc_reg <= aes_pkg::xt(rc_reg);
            end
            win_reg[0] <= w_new;
            for (int j = 1; j < 8; j++)
            begin
                win_reg[j] <= win_reg[j - 1];
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg & last;
    assign stat.we   = busy_reg & (i_reg[1:0] == 2'd3);
    assign wr_addr   = i_reg[WI_W-1:2];
    assign wr_data   = {win_reg[2], win_reg[1], win_reg[0], w_new};

endmodule

// File: hw/rtl/aes_round.sv
// One AES round, forward or inverse, shared by every round of a block.
// Depends on aes_pkg.
`timescale 1ns / 1ps

module aes_round (
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         dec,
    input  logic         last,
    output logic [127:0] state_out
);

    logic [127:0] sb;
    logic [127:0] mixed;

    always_comb
    begin
        if (dec)
        begin
            sb    = aes_pkg::sub_bytes(aes_pkg::shift_rows(state_in, 1'b1), 1'b1) ^ round_key;
            mixed = aes_pkg::mix_columns(sb, 1'b1);
            state_out = last ? sb : mixed;
        end
        else
        begin
            sb    = aes_pkg::shift_rows(aes_pkg::sub_bytes(state_in, 1'b0), 1'b0);
            mixed = aes_pkg::mix_columns(sb, 1'b0);
            state_out = (last ? sb : mixed) ^ round_key;
        end
    end

endmodule

// File: sim/aes_block_cipher_ecb_cbc_tb.sv
// Self-checking testbench for the AES ECB/CBC block cipher: directed known keys,
// every key size and mode, then random traffic against an in-bench AES predictor.
// Depends on aes_pkg, aes_in_if/aes_out_if and the aes_block_cipher_ecb_cbc top.
`timescale 1ns / 1ps

module aes_block_cipher_ecb_cbc_tb;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    aes_in_if  in_ch();
    aes_out_if out_ch();

    aes_block_cipher_ecb_cbc dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .blk_in  (in_ch),
        .blk_out (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bit [7:0]   sb_fwd [256];
    bit [7:0]   sb_inv [256];
    bit [63:0]  key_w [4];
    bit [63:0]  iv_h;
    bit [63:0]  iv_l;
    bit [1:0]   key_sz;
    bit [1:0]   cipher_mode;
    bit [31:0]  sched [60];
    bit         sched_valid;
    int         n_rounds;
    bit [127:0] chain_val;
    bit [127:0] pending_blocks [$];
    bit         quiet;
    int         n_errors;
    int         idle_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit [7:0] gf_mul(bit [7:0] a, bit [7:0] b);
        bit [7:0] r;
        r = 0;
        for (int k = 0; k < 8; k++)
        begin
            if (a[0])
                r ^= b;
            a = a >> 1;
            b = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
        end
        return r;
    endfunction

    function automatic bit [7:0] rotl8(bit [7:0] v, int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    task automatic build_sboxes();
        bit [7:0] p;
        bit [7:0] b;
        for (int x = 0; x < 256; x++)
        begin
            p = 8'h01;
            if (x == 0)
                p = 8'h00;
            else
                for (int k = 0; k < 254; k++)
                    p = gf_mul(p, x[7:0]);
            b = p ^ rotl8(p, 1) ^ rotl8(p, 2) ^ rotl8(p, 3) ^ rotl8(p, 4) ^ 8'h63;
            sb_fwd[x] = b;
            sb_inv[b] = x[7:0];
        end
    endtask

    function automatic bit [31:0] sub_w(bit [31:0] w);
        return {sb_fwd[w[31:24]], sb_fwd[w[23:16]], sb_fwd[w[15:8]], sb_fwd[w[7:0]]};
    endfunction

    function automatic void expand_schedule();
        int sel;
        int nk;
        int total;
        bit [7:0] rc;
        bit [31:0] t;
        bit [31:0] kw [8];
        sel = (key_sz > 2) ? 2 : key_sz;
        while (sel > 0 && 4 * (10 + 2 * sel + 1) > 60)
            sel--;
        nk = 4 + 2 * sel;
        n_rounds = 10 + 2 * sel;
        total = 4 * (n_rounds + 1);
        rc = 8'h01;
        for (int i = 0; i < 4; i++)
        begin
            kw[2 * i] = key_w[i][63:32];
            kw[2 * i + 1] = key_w[i][31:0];
        end
        for (int i = 0; i < nk; i++)
            sched[i] = kw[i];
        for (int i = nk; i < total; i++)
        begin
            t = sched[i - 1];
            if (i % nk == 0)
            begin
                t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_mul(rc, 8'h02);
            end
            else if (nk == 8 && i % 4 == 0)
                t = sub_w(t);
            sched[i] = sched[i - nk] ^ t;
        end
        sched_valid = 1'b1;
    endfunction

    function automatic bit [7:0] byte_at(bit [127:0] s, int n);
        return s[127 - 8 * n -: 8];
    endfunction

    function automatic bit [127:0] st_sub(bit [127:0] s, bit inv);
        bit [127:0] t;
        for (int n = 0; n < 16; n++)
            t[127 - 8 * n -: 8] = inv ? sb_inv[byte_at(s, n)] : sb_fwd[byte_at(s, n)];
        return t;
    endfunction

    function automatic bit [127:0] st_shift(bit [127:0] s, bit inv);
        bit [127:0] t;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
                t[127 - 8 * (4 * c + r) -: 8] = byte_at(s, 4 * src + r);
            end
        return t;
    endfunction

    function automatic bit [127:0] st_mix(bit [127:0] s, bit inv);
        bit [127:0] t;
        bit [7:0] m [4];
        bit [7:0] v;
        if (inv)
            m = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
        else
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                v = 0;
                for (int k = 0; k < 4; k++)
                    v ^= gf_mul(m[(k + 4 - r) & 3], byte_at(s, 4 * c + k));
                t[127 - 8 * (4 * c + r) -: 8] = v;
            end
        return t;
    endfunction

    function automatic bit [127:0] st_key(bit [127:0] s, int rnd);
        return s ^ {sched[4 * rnd], sched[4 * rnd + 1], sched[4 * rnd + 2], sched[4 * rnd + 3]};
    endfunction

    // advance the cipher and chain state for one accepted block
    function automatic bit [127:0] aes_transform(bit [127:0] blk, bit first);
        bit [127:0] s;
        bit [127:0] ch;
        bit cbc;
        bit dec;
        cbc = cipher_mode[0];
        dec = cipher_mode[1];
        if (!sched_valid)
            expand_schedule();
        ch = first ? {iv_h, iv_l} : chain_val;
        s = blk;
        if (!dec)
        begin
            if (cbc)
                s ^= ch;
            s = st_key(s, 0);
            for (int r = 1; r <= n_rounds; r++)
            begin
                s = st_shift(st_sub(s, 1'b0), 1'b0);
                if (r != n_rounds)
                    s = st_mix(s, 1'b0);
                s = st_key(s, r);
            end
            chain_val = s;
        end
        else
        begin
            s = st_key(s, n_rounds);
            for (int r = n_rounds - 1; r >= 1; r--)
                s = st_mix(st_key(st_sub(st_shift(s, 1'b1), 1'b1), r), 1'b1);
            s = st_key(st_sub(st_shift(s, 1'b1), 1'b1), 0);
            if (cbc)
                s ^= ch;
            chain_val = blk;
        end
        return s;
    endfunction

    task automatic wait_idle();
        wait (pending_blocks.size() == 0);
        repeat (130) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, bit [63:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            aes_pkg::REG_KEY0, aes_pkg::REG_KEY1, aes_pkg::REG_KEY2, aes_pkg::REG_KEY3:
            begin
                key_w[idx[1:0]] = value;
                sched_valid = 1'b0;
            end
            aes_pkg::REG_IV_HIGH: iv_h = value;
            aes_pkg::REG_IV_LOW:  iv_l = value;
            aes_pkg::REG_KEYSIZE:
            begin
                key_sz = value[1:0];
                sched_valid = 1'b0;
            end
            aes_pkg::REG_OPMODE:  cipher_mode = value[1:0];
            default: ;
        endcase
    endtask

    task automatic load_setup(bit [63:0] k0, bit [63:0] k1, bit [63:0] k2, bit [63:0] k3,
                              bit [63:0] ivh, bit [63:0] ivl, bit [1:0] ksz, bit [1:0] md);
        wait_idle();
        reg_write(aes_pkg::REG_KEY0, k0);
        reg_write(aes_pkg::REG_KEY1, k1);
        reg_write(aes_pkg::REG_KEY2, k2);
        reg_write(aes_pkg::REG_KEY3, k3);
        reg_write(aes_pkg::REG_IV_HIGH, ivh);
        reg_write(aes_pkg::REG_IV_LOW, ivl);
        reg_write(aes_pkg::REG_KEYSIZE, {62'd0, ksz});
        reg_write(aes_pkg::REG_OPMODE, {62'd0, md});
    endtask

    task automatic send_block(bit [63:0] hi, bit [63:0] lo, bit first);
        @(negedge clk);
        if (!quiet && $urandom_range(3) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.block_hi = hi;
        in_ch.block_lo = lo;
        in_ch.first_block = first;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_blocks.push_back(aes_transform({hi, lo}, first));
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_reset_state();
        send_block(64'h0, 64'h0, 1'b0);
        send_block('1, '1, 1'b1);
        drop_valid();
        wait_idle();
        reg_write(aes_pkg::REG_OPMODE, {62'd0, 2'b01});
        send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF, 1'b0);
        drop_valid();
    endtask

    task automatic test_known_keys();
        for (int ks = 0; ks < 4; ks++)
        begin
            load_setup(64'h0001020304050607, 64'h08090A0B0C0D0E0F,
                       64'h1011121314151617, 64'h18191A1B1C1D1E1F,
                       64'h0, 64'h0, ks[1:0], 2'b00);
            send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF, 1'b0);
            drop_valid();
            wait_idle();
            reg_write(aes_pkg::REG_OPMODE, {62'd0, 2'b10});
            send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF, 1'b1);
            drop_valid();
        end
    endtask

    task automatic test_cbc_chain();
        load_setup('1, '1, '1, '1, '1, '1, 2'd2, 2'b01);
        send_block(64'h0, 64'h0, 1'b1);
        send_block('1, '1, 1'b0);
        send_block(64'h8000000000000001, 64'h0123456789ABCDEF, 1'b0);
        send_block(64'h0, 64'h0, 1'b1);
        drop_valid();
        wait_idle();
        reg_write(aes_pkg::REG_OPMODE, {62'd0, 2'b11});
        send_block(64'h0, 64'h0, 1'b1);
        send_block('1, '1, 1'b0);
        send_block(64'h0, '1, 1'b0);
        drop_valid();
        load_setup(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 2'd1, 2'b11);
        send_block(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 1'b0);
        drop_valid();
    endtask

    task automatic test_random_traffic();
        int n_sent;
        int msg_left;
        n_sent = 0;
        while (n_sent < 720)
        begin
            if (n_sent >= 600)
                quiet = 1'b1;
            load_setup(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                       2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            msg_left = 0;
            repeat ($urandom_range(15, 40))
            begin
                if (msg_left == 0)
                    msg_left = $urandom_range(1, 8);
                send_block(rand64(), rand64(),
                           (msg_left == 1 && $urandom_range(1) == 0) ? 1'b0 : 1'b1);
                msg_left--;
                if (msg_left > 0)
                begin
                    // mid-message blocks: rarely restart the chain
                    send_block(rand64(), rand64(), $urandom_range(9) == 0);
                    n_sent++;
                end
                n_sent++;
            end
            drop_valid();
        end
    endtask

    // result side: random stall bursts, then check each transfer
    initial
    begin
        int hold;
        out_ch.ready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ch.ready = 1'b0;
            end
            else if (!quiet && $urandom_range(4) == 0)
            begin
                hold = $urandom_range(0, 3);
                out_ch.ready = 1'b0;
            end
            else
                out_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        bit [127:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_blocks.size() == 0)
            begin
                $display("%0t: unexpected result %h %h", $time,
                         out_ch.result_hi, out_ch.result_lo);
                n_errors++;
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (out_ch.result_hi !== want[127:64])
                begin
                    $display("%0t: result_hi expected %h actual %h", $time,
                             want[127:64], out_ch.result_hi);
                    n_errors++;
                end
                if (out_ch.result_lo !== want[63:0])
                begin
                    $display("%0t: result_lo expected %h actual %h", $time,
                             want[63:0], out_ch.result_lo);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 3000)
        begin
            $display("aes_block_cipher_ecb_cbc_tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.block_hi = '0;
        in_ch.block_lo = '0;
        in_ch.first_block = 1'b0;
        quiet = 1'b0;
        n_errors = 0;
        idle_cycles = 0;
        key_w = '{default: 64'h0};
        iv_h = 0;
        iv_l = 0;
        key_sz = 0;
        cipher_mode = 0;
        sched_valid = 1'b0;
        n_rounds = 10;
        chain_val = 0;
        build_sboxes();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_known_keys();
        test_cbc_chain();
        test_random_traffic();

        wait (pending_blocks.size() == 0);
        repeat (40) @(posedge clk);
        if (n_errors == 0)
            $display("aes_block_cipher_ecb_cbc_tb: clean");
        else
            $display("aes_block_cipher_ecb_cbc_tb: errors");
        $finish;
    end

endmodule

// File: aes_block_cipher_ecb_cbc.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_if.sv
hw/rtl/aes_key_exp.sv
hw/rtl/aes_round.sv
hw/rtl/aes_block_cipher_ecb_cbc.sv
sim/aes_block_cipher_ecb_cbc_tb.sv
